[rtl/core/ddsf_pkg.sv]
// ddsf_pkg: shared types, register codes and arithmetic helpers for the
// differential drive mixer with slew limit and failsafe.
// no dependencies; used by diff_drive_slew_failsafe and ddsf_checker.
package ddsf_pkg;

   // item opcodes
   localparam logic OP_DRIVE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // configuration register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_DEADBAND         = 3'd0;
   localparam logic [2:0] REG_SLEW_STEP        = 3'd1;
   localparam logic [2:0] REG_SLEW_STEP_STOP   = 3'd2;
   localparam logic [2:0] REG_FAILSAFE_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_MIN_PWM          = 3'd4;

   // register reset values
   localparam logic [6:0]  DEADBAND_RST       = 7'd0;
   localparam logic [7:0]  SLEW_STEP_RST      = 8'd5;
   localparam logic [7:0]  SLEW_STEP_STOP_RST = 8'd10;
   localparam logic [15:0] TIMEOUT_RST        = 16'd0;
   localparam logic [7:0]  MIN_PWM_RST        = 8'd0;

   localparam logic [15:0] PWM_FULL_SCALE = 16'd255;
   localparam logic [16:0] TIMER_MAX      = 17'h1FFFF;

   // speed limits in percent
   localparam logic signed [7:0] SPEED_MAX = 8'sd100;
   localparam logic signed [7:0] SPEED_MIN = -8'sd100;

   // x / 100 == (x * 5243) >> 19 for every x below 43699
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // duty saturates at 255 once mag * full scale reaches 25600
   localparam logic [22:0] DUTY_SAT_PRODUCT = 23'd25600;
   localparam logic [7:0]  DUTY_MAX         = 8'd255;

   typedef logic signed [7:0]  speed_type;
   typedef logic signed [14:0] cmd_prod_type;

   typedef struct packed {
      logic       dir_a;
      logic       dir_b;
      logic [7:0] pwm;
   } bridge_type;

   function automatic speed_type clamp_axis(input logic signed [15:0] v);
      if (v < 16'(SPEED_MIN)) begin
         return SPEED_MIN;
      end else if (v > 16'(SPEED_MAX)) begin
         return SPEED_MAX;
      end
      return speed_type'(v[7:0]);
   endfunction

   function automatic logic [6:0] clamp_throttle(input logic signed [15:0] v);
      if (v < 16'sd0) begin
         return 7'd0;
      end else if (v > 16'(SPEED_MAX)) begin
         return 7'(SPEED_MAX);
      end
      return v[6:0];
   endfunction

   function automatic speed_type clamp_mix(input logic signed [8:0] v);
      if (v < 9'(SPEED_MIN)) begin
         return SPEED_MIN;
      end else if (v > 9'(SPEED_MAX)) begin
         return SPEED_MAX;
      end
      return speed_type'(v[7:0]);
   endfunction

   function automatic logic [6:0] div100(input logic [13:0] mag);
      logic [26:0] p;
      p = 27'(mag) * 27'(DIV100_MUL);
      return p[DIV100_SHIFT +: 7];
   endfunction

   // commanded speed (truncated toward zero) after the deadband
   function automatic speed_type cmd_target(input cmd_prod_type p,
                                            input logic [6:0] deadband);
      logic [13:0] mag;
      logic [6:0]  q;
      mag = p[14] ? 14'(-p) : 14'(p);
      q   = div100(mag);
      if (q < deadband) begin
         return 8'sd0;
      end
      return p[14] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   function automatic speed_type slew(input speed_type cur, input speed_type tgt,
                                      input logic [7:0] step,
                                      input logic [7:0] step_stop);
      logic signed [9:0] d;
      logic signed [9:0] lim;
      logic signed [9:0] sum;
      lim = $signed({2'b00, (tgt == 8'sd0) ? step_stop : step});
      d   = 10'(tgt) - 10'(cur);
      if (d > lim) begin
         d = lim;
      end else if (d < -lim) begin
         d = -lim;
      end
      sum = 10'(cur) + d;
      return speed_type'(sum[7:0]);
   endfunction

   function automatic bridge_type bridge(input speed_type s, input logic [7:0] min_pwm);
      bridge_type  b;
      logic [7:0]  mag;
      logic [22:0] prod;
      logic [27:0] q;
      logic [7:0]  duty;
      mag = s[7] ? 8'(-s) : 8'(s);
      if (mag > 8'(SPEED_MAX)) begin
         mag = 8'(SPEED_MAX);
      end
      prod = 23'(mag[6:0]) * 23'(PWM_FULL_SCALE);
      q    = 28'(prod[14:0]) * 28'(DIV100_MUL);
      if (prod >= DUTY_SAT_PRODUCT) begin
         duty = DUTY_MAX;
      end else begin
         duty = q[DIV100_SHIFT +: 8];
      end
      if (duty != 8'd0 && duty < min_pwm) begin
         duty = min_pwm;
      end
      if (s == 8'sd0) begin
         b.dir_a = 1'b1;
         b.dir_b = 1'b1;
         b.pwm   = 8'd0;
      end else begin
         b.dir_a = ~s[7];
         b.dir_b = s[7];
         b.pwm   = duty;
      end
      return b;
   endfunction

endpackage

[rtl/core/diff_drive_slew_failsafe.sv]
// diff_drive_slew_failsafe: two-motor differential drive mixer with slew
// limit, command failsafe timer and H-bridge drive encoding.
// depends on ddsf_pkg.
//
// usage:
//   req channel (valid/ready) carries one transaction per item: opcode 0 is a
//   drive command (joystick x, y and throttle), opcode 1 is an update tick
//   (elapsed milliseconds). every transaction yields exactly one rsp
//   transaction with both speeds, bridge drive, failsafe and change flags.
//   csr is an apb-style port with five 32-bit registers at 0x00..0x10:
//   deadband, slew_step, slew_step_stop, failsafe_timeout_ms, min_pwm.
//   a req passes the input register, snapshot stage and result register to rsp.
//   throughput: one transaction per cycle while rsp_ready stays high; the motor
//   state loop (timer, deadband, slew) closes combinationally between the input
//   register and the snapshot stage, and bridge encoding runs in the stage after it.
//   a stalled rsp holds its register; the input register and the snapshot
//   stage keep taking transactions until both are full, then req_ready drops.
//   reset (synchronous) empties the pipeline, zeroes speeds, commands and
//   timer, clears failsafe and loads the register defaults.
module diff_drive_slew_failsafe
   import ddsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [15:0] req_joystick_x,
   input  logic signed [15:0] req_joystick_y,
   input  logic signed [15:0] req_throttle,
   input  logic        [15:0] req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [7:0]  rsp_left_speed,
   output logic signed [7:0]  rsp_right_speed,
   output logic               rsp_left_dir_a,
   output logic               rsp_left_dir_b,
   output logic        [7:0]  rsp_left_pwm,
   output logic               rsp_right_dir_a,
   output logic               rsp_right_dir_b,
   output logic        [7:0]  rsp_right_pwm,
   output logic               rsp_failsafe_active,
   output logic               rsp_outputs_changed,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic        [4:0]  csr_paddr,
   input  logic        [31:0] csr_pwdata,
   output logic        [31:0] csr_prdata,
   output logic               csr_pready
);

   // configuration registers
   logic [6:0]  deadband_ff, deadband_in;
   logic [7:0]  slew_step_ff, slew_step_in;
   logic [7:0]  slew_stop_ff, slew_stop_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  min_pwm_ff, min_pwm_in;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_opcode_ff, s1_opcode_in;
   logic signed [15:0] s1_x_ff, s1_x_in;
   logic signed [15:0] s1_y_ff, s1_y_in;
   logic signed [15:0] s1_thr_ff, s1_thr_in;
   logic        [15:0] s1_elapsed_ff, s1_elapsed_in;

   // motor state
   cmd_prod_type cmd_left_ff, cmd_left_in;
   cmd_prod_type cmd_right_ff, cmd_right_in;
   speed_type    out_left_ff, out_left_in;
   speed_type    out_right_ff, out_right_in;
   logic [16:0]  timer_ff, timer_in;
   logic         failsafe_ff, failsafe_in;

   // snapshot stage
   logic      s2_valid_ff, s2_valid_in;
   speed_type s2_left_ff, s2_left_in;
   speed_type s2_right_ff, s2_right_in;
   logic      s2_failsafe_ff, s2_failsafe_in;
   logic      s2_changed_ff, s2_changed_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   speed_type  rsp_left_ff, rsp_left_in;
   speed_type  rsp_right_ff, rsp_right_in;
   bridge_type rsp_lbr_ff, rsp_lbr_in;
   bridge_type rsp_rbr_ff, rsp_rbr_in;
   logic       rsp_failsafe_ff, rsp_failsafe_in;
   logic       rsp_changed_ff, rsp_changed_in;

   logic adv1, adv2, adv3;
   logic step_fire;
   logic csr_write;

   speed_type    ax_x, ax_y, mix_l, mix_r;
   logic [6:0]   thr;
   cmd_prod_type prod_l, prod_r;
   logic [17:0]  timer_sum;
   logic [16:0]  timer_tick;
   logic         fs_tick;
   speed_type    tgt_l, tgt_r, new_l, new_r;

   // ---------------- flow control ----------------
   assign adv3      = ~rsp_valid_ff | rsp_ready;
   assign adv2      = ~s2_valid_ff | adv3;
   assign adv1      = ~s1_valid_ff | adv2;
   assign step_fire = s1_valid_ff & adv2;
   assign req_ready = adv1;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      deadband_in  = deadband_ff;
      slew_step_in = slew_step_ff;
      slew_stop_in = slew_stop_ff;
      timeout_in   = timeout_ff;
      min_pwm_in   = min_pwm_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_DEADBAND:         deadband_in  = csr_pwdata[6:0];
            REG_SLEW_STEP:        slew_step_in = csr_pwdata[7:0];
            REG_SLEW_STEP_STOP:   slew_stop_in = csr_pwdata[7:0];
            REG_FAILSAFE_TIMEOUT: timeout_in   = csr_pwdata[15:0];
            REG_MIN_PWM:          min_pwm_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_DEADBAND:         csr_prdata = 32'(deadband_ff);
         REG_SLEW_STEP:        csr_prdata = 32'(slew_step_ff);
         REG_SLEW_STEP_STOP:   csr_prdata = 32'(slew_stop_ff);
         REG_FAILSAFE_TIMEOUT: csr_prdata = 32'(timeout_ff);
         REG_MIN_PWM:          csr_prdata = 32'(min_pwm_ff);
         default:              csr_prdata = 32'd0;
      endcase
   end

   // ---------------- input register ----------------
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_opcode_in  = s1_opcode_ff;
      s1_x_in       = s1_x_ff;
      s1_y_in       = s1_y_ff;
      s1_thr_in     = s1_thr_ff;
      s1_elapsed_in = s1_elapsed_ff;
      if (adv1) begin
         s1_valid_in   = req_valid;
         s1_opcode_in  = req_opcode;
         s1_x_in       = req_joystick_x;
         s1_y_in       = req_joystick_y;
         s1_thr_in     = req_throttle;
         s1_elapsed_in = req_elapsed_ms;
      end
   end

   // ---------------- drive command math ----------------
   always_comb begin
      ax_x   = clamp_axis(s1_x_ff);
      ax_y   = clamp_axis(s1_y_ff);
      thr    = clamp_throttle(s1_thr_ff);
      mix_l  = clamp_mix(9'(ax_y) + 9'(ax_x));
      mix_r  = clamp_mix(9'(ax_y) - 9'(ax_x));
      prod_l = cmd_prod_type'(mix_l) * cmd_prod_type'($signed({1'b0, thr}));
      prod_r = cmd_prod_type'(mix_r) * cmd_prod_type'($signed({1'b0, thr}));
   end

   // ---------------- tick math ----------------
   always_comb begin
      timer_sum  = 18'(timer_ff) + 18'(s1_elapsed_ff);
      timer_tick = (timer_sum > 18'(TIMER_MAX)) ? TIMER_MAX : timer_sum[16:0];
      fs_tick    = failsafe_ff | ((timeout_ff != 16'd0) & (timer_tick > 17'(timeout_ff)));
      tgt_l      = fs_tick ? 8'sd0 : cmd_target(cmd_left_ff, deadband_ff);
      tgt_r      = fs_tick ? 8'sd0 : cmd_target(cmd_right_ff, deadband_ff);
      new_l      = slew(out_left_ff, tgt_l, slew_step_ff, slew_stop_ff);
      new_r      = slew(out_right_ff, tgt_r, slew_step_ff, slew_stop_ff);
   end

   // ---------------- state update and snapshot ----------------
   always_comb begin
      cmd_left_in    = cmd_left_ff;
      cmd_right_in   = cmd_right_ff;
      out_left_in    = out_left_ff;
      out_right_in   = out_right_ff;
      timer_in       = timer_ff;
      failsafe_in    = failsafe_ff;
      s2_valid_in    = s2_valid_ff;
      s2_left_in     = s2_left_ff;
      s2_right_in    = s2_right_ff;
      s2_failsafe_in = s2_failsafe_ff;
      s2_changed_in  = s2_changed_ff;
      if (adv2) begin
         s2_valid_in = s1_valid_ff;
      end
      if (step_fire) begin
         if (s1_opcode_ff == OP_DRIVE) begin
            cmd_left_in    = prod_l;
            cmd_right_in   = prod_r;
            timer_in       = 17'd0;
            failsafe_in    = 1'b0;
            s2_left_in     = out_left_ff;
            s2_right_in    = out_right_ff;
            s2_failsafe_in = 1'b0;
            s2_changed_in  = 1'b0;
         end else begin
            out_left_in    = new_l;
            out_right_in   = new_r;
            timer_in       = timer_tick;
            failsafe_in    = fs_tick;
            s2_left_in     = new_l;
            s2_right_in    = new_r;
            s2_failsafe_in = fs_tick;
            s2_changed_in  = (new_l != out_left_ff) | (new_r != out_right_ff);
         end
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_lbr_in      = rsp_lbr_ff;
      rsp_rbr_in      = rsp_rbr_ff;
      rsp_failsafe_in = rsp_failsafe_ff;
      rsp_changed_in  = rsp_changed_ff;
      if (adv3) begin
         rsp_valid_in    = s2_valid_ff;
         rsp_left_in     = s2_left_ff;
         rsp_right_in    = s2_right_ff;
         rsp_lbr_in      = bridge(s2_left_ff, min_pwm_ff);
         rsp_rbr_in      = bridge(s2_right_ff, min_pwm_ff);
         rsp_failsafe_in = s2_failsafe_ff;
         rsp_changed_in  = s2_changed_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RST;
         slew_step_ff <= SLEW_STEP_RST;
         slew_stop_ff <= SLEW_STEP_STOP_RST;
         timeout_ff   <= TIMEOUT_RST;
         min_pwm_ff   <= MIN_PWM_RST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_left_ff  <= '0;
         cmd_right_ff <= '0;
         out_left_ff  <= '0;
         out_right_ff <= '0;
         timer_ff     <= '0;
         failsafe_ff  <= 1'b0;
      end else begin
         deadband_ff  <= deadband_in;
         slew_step_ff <= slew_step_in;
         slew_stop_ff <= slew_stop_in;
         timeout_ff   <= timeout_in;
         min_pwm_ff   <= min_pwm_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_left_ff  <= cmd_left_in;
         cmd_right_ff <= cmd_right_in;
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
         timer_ff     <= timer_in;
         failsafe_ff  <= failsafe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_opcode_ff    <= s1_opcode_in;
      s1_x_ff         <= s1_x_in;
      s1_y_ff         <= s1_y_in;
      s1_thr_ff       <= s1_thr_in;
      s1_elapsed_ff   <= s1_elapsed_in;
      s2_left_ff      <= s2_left_in;
      s2_right_ff     <= s2_right_in;
      s2_failsafe_ff  <= s2_failsafe_in;
      s2_changed_ff   <= s2_changed_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_lbr_ff      <= rsp_lbr_in;
      rsp_rbr_ff      <= rsp_rbr_in;
      rsp_failsafe_ff <= rsp_failsafe_in;
      rsp_changed_ff  <= rsp_changed_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_speed      = rsp_left_ff;
   assign rsp_right_speed     = rsp_right_ff;
   assign rsp_left_dir_a      = rsp_lbr_ff.dir_a;
   assign rsp_left_dir_b      = rsp_lbr_ff.dir_b;
   assign rsp_left_pwm        = rsp_lbr_ff.pwm;
   assign rsp_right_dir_a     = rsp_rbr_ff.dir_a;
   assign rsp_right_dir_b     = rsp_rbr_ff.dir_b;
   assign rsp_right_pwm       = rsp_rbr_ff.pwm;
   assign rsp_failsafe_active = rsp_failsafe_ff;
   assign rsp_outputs_changed = rsp_changed_ff;

endmodule

[rtl/core/ddsf_checker.sv]
// ddsf_checker: port-level assertions for diff_drive_slew_failsafe, bound
// to the top level below.
// depends on ddsf_pkg.
module ddsf_checker
   import ddsf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_left_speed,
   input logic signed [7:0] rsp_right_speed,
   input logic              rsp_left_dir_a,
   input logic              rsp_left_dir_b,
   input logic        [7:0] rsp_left_pwm,
   input logic              rsp_right_dir_a,
   input logic              rsp_right_dir_b,
   input logic        [7:0] rsp_right_pwm
);

   // a stalled transaction keeps its speeds and pwm duties
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed)
         && $stable(rsp_right_speed) && $stable(rsp_left_pwm) && $stable(rsp_right_pwm))
      else $error("rsp transaction changed while stalled");

   // no rsp transaction offered right after reset
   reset_empty_a: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // speeds stay within the percent range
   speed_range_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_speed <= SPEED_MAX && rsp_left_speed >= SPEED_MIN
         && rsp_right_speed <= SPEED_MAX && rsp_right_speed >= SPEED_MIN)
      else $error("speed out of range");

   // zero speed brakes with no duty, otherwise direction follows the sign
   left_bridge_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed == 8'sd0)
         ? (rsp_left_dir_a && rsp_left_dir_b && rsp_left_pwm == 8'd0)
         : (rsp_left_dir_b == rsp_left_speed[7] && rsp_left_dir_a != rsp_left_dir_b))
      else $error("left bridge drive does not match speed");

   right_bridge_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_speed == 8'sd0)
         ? (rsp_right_dir_a && rsp_right_dir_b && rsp_right_pwm == 8'd0)
         : (rsp_right_dir_b == rsp_right_speed[7] && rsp_right_dir_a != rsp_right_dir_b))
      else $error("right bridge drive does not match speed");

endmodule

bind diff_drive_slew_failsafe ddsf_checker u_ddsf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_left_speed  (rsp_left_speed),
   .rsp_right_speed (rsp_right_speed),
   .rsp_left_dir_a  (rsp_left_dir_a),
   .rsp_left_dir_b  (rsp_left_dir_b),
   .rsp_left_pwm    (rsp_left_pwm),
   .rsp_right_dir_a (rsp_right_dir_a),
   .rsp_right_dir_b (rsp_right_dir_b),
   .rsp_right_pwm   (rsp_right_pwm)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

// testbench.sv: self-checking bench for diff_drive_slew_failsafe; a scoreboard class
// predicts every motor status transaction and compares it field by field.
// depends on ddsf_pkg and the diff_drive_slew_failsafe rtl.

typedef struct {
   logic signed [7:0] left_speed;
   logic signed [7:0] right_speed;
   logic              left_dir_a;
   logic              left_dir_b;
   logic [7:0]        left_pwm;
   logic              right_dir_a;
   logic              right_dir_b;
   logic [7:0]        right_pwm;
   logic              failsafe_active;
   logic              outputs_changed;
} motor_status_type;

class motor_status_scoreboard;
   logic [6:0]       deadband;
   logic [7:0]       slew_step;
   logic [7:0]       slew_step_stop;
   logic [15:0]      timeout_ms;
   logic [7:0]       min_pwm;
   int               cmd_left;
   int               cmd_right;
   int               out_left;
   int               out_right;
   int               since_drive_ms;
   bit               failsafe;
   motor_status_type expected_status_q[$];
   int               mismatches;
   int               checked;

   function new();
      deadband       = ddsf_pkg::DEADBAND_RST;
      slew_step      = ddsf_pkg::SLEW_STEP_RST;
      slew_step_stop = ddsf_pkg::SLEW_STEP_STOP_RST;
      timeout_ms     = ddsf_pkg::TIMEOUT_RST;
      min_pwm        = ddsf_pkg::MIN_PWM_RST;
      cmd_left       = 0;
      cmd_right      = 0;
      out_left       = 0;
      out_right      = 0;
      since_drive_ms = 0;
      failsafe       = 1'b0;
      mismatches     = 0;
      checked        = 0;
   endfunction

   function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
         ddsf_pkg::REG_DEADBAND:         deadband       = value[6:0];
         ddsf_pkg::REG_SLEW_STEP:        slew_step      = value[7:0];
         ddsf_pkg::REG_SLEW_STEP_STOP:   slew_step_stop = value[7:0];
         ddsf_pkg::REG_FAILSAFE_TIMEOUT: timeout_ms     = value[15:0];
         ddsf_pkg::REG_MIN_PWM:          min_pwm        = value[7:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] register_value(logic [2:0] idx);
      case (idx)
         ddsf_pkg::REG_DEADBAND:         return 32'(deadband);
         ddsf_pkg::REG_SLEW_STEP:        return 32'(slew_step);
         ddsf_pkg::REG_SLEW_STEP_STOP:   return 32'(slew_step_stop);
         ddsf_pkg::REG_FAILSAFE_TIMEOUT: return 32'(timeout_ms);
         ddsf_pkg::REG_MIN_PWM:          return 32'(min_pwm);
         default:                        return '0;
      endcase
   endfunction

   function int clamp(int v, int lo, int hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function int past_deadband(int v);
      return (((v < 0) ? -v : v) < int'(deadband)) ? 0 : v;
   endfunction

   // braking toward zero uses the stop step
   function int step_toward(int cur, int tgt);
      int d;
      int lim;
      d   = tgt - cur;
      lim = (tgt == 0) ? int'(slew_step_stop) : int'(slew_step);
      if (d > lim) begin
         d = lim;
      end
      if (d < -lim) begin
         d = -lim;
      end
      return cur + d;
   endfunction

   function void drive_bridge(int s, output logic a, output logic b, output logic [7:0] pwm);
      int mag;
      int duty;
      if (s == 0) begin
         a   = 1'b1;
         b   = 1'b1;
         pwm = 8'd0;
         return;
      end
      a    = (s > 0);
      b    = (s < 0);
      mag  = (s > 0) ? s : -s;
      mag  = clamp(mag, 0, 100);
      duty = mag * int'(ddsf_pkg::PWM_FULL_SCALE) / 100;
      if (duty > 255) begin
         duty = 255;
      end
      if (duty > 0 && duty < int'(min_pwm)) begin
         duty = int'(min_pwm);
      end
      pwm = 8'(duty);
   endfunction

   function void note_item(logic opcode, logic signed [15:0] jx, logic signed [15:0] jy,
                           logic signed [15:0] thr, logic [15:0] elapsed);
      int               x;
      int               y;
      int               t;
      int               l;
      int               r;
      int               nl;
      int               nr;
      bit               changed;
      motor_status_type s;
      changed = 1'b0;
      if (opcode == ddsf_pkg::OP_DRIVE) begin
         x              = clamp(int'(jx), -100, 100);
         y              = clamp(int'(jy), -100, 100);
         t              = clamp(int'(thr), 0, 100);
         l              = clamp(y + x, -100, 100);
         r              = clamp(y - x, -100, 100);
         cmd_left       = (l * t) / 100;
         cmd_right      = (r * t) / 100;
         since_drive_ms = 0;
         failsafe       = 1'b0;
      end else begin
         since_drive_ms = clamp(since_drive_ms + int'(elapsed), 0,
                                int'(ddsf_pkg::TIMER_MAX));
         if (timeout_ms != 16'd0 && since_drive_ms > int'(timeout_ms)) begin
            failsafe = 1'b1;
         end
         nl        = step_toward(out_left, failsafe ? 0 : past_deadband(cmd_left));
         nr        = step_toward(out_right, failsafe ? 0 : past_deadband(cmd_right));
         changed   = (nl != out_left) || (nr != out_right);
         out_left  = nl;
         out_right = nr;
      end
      s.left_speed  = 8'(out_left);
      s.right_speed = 8'(out_right);
      drive_bridge(out_left, s.left_dir_a, s.left_dir_b, s.left_pwm);
      drive_bridge(out_right, s.right_dir_a, s.right_dir_b, s.right_pwm);
      s.failsafe_active = failsafe;
      s.outputs_changed = changed;
      expected_status_q.push_back(s);
   endfunction

   task report_mismatch(string what, int got, int want);
      $display("mismatch at status %0d: %s got %0d expected %0d", checked, what, got, want);
      mismatches++;
   endtask

   task check_status(motor_status_type got);
      motor_status_type want;
      if (expected_status_q.size() == 0) begin
         report_mismatch("transaction with none pending", 1, 0);
         checked++;
         return;
      end
      want = expected_status_q.pop_front();
      if (got.left_speed !== want.left_speed)
         report_mismatch("left_speed", got.left_speed, want.left_speed);
      if (got.right_speed !== want.right_speed)
         report_mismatch("right_speed", got.right_speed, want.right_speed);
      if (got.left_dir_a !== want.left_dir_a)
         report_mismatch("left_dir_a", got.left_dir_a, want.left_dir_a);
      if (got.left_dir_b !== want.left_dir_b)
         report_mismatch("left_dir_b", got.left_dir_b, want.left_dir_b);
      if (got.left_pwm !== want.left_pwm)
         report_mismatch("left_pwm", got.left_pwm, want.left_pwm);
      if (got.right_dir_a !== want.right_dir_a)
         report_mismatch("right_dir_a", got.right_dir_a, want.right_dir_a);
      if (got.right_dir_b !== want.right_dir_b)
         report_mismatch("right_dir_b", got.right_dir_b, want.right_dir_b);
      if (got.right_pwm !== want.right_pwm)
         report_mismatch("right_pwm", got.right_pwm, want.right_pwm);
      if (got.failsafe_active !== want.failsafe_active)
         report_mismatch("failsafe_active", got.failsafe_active, want.failsafe_active);
      if (got.outputs_changed !== want.outputs_changed)
         report_mismatch("outputs_changed", got.outputs_changed, want.outputs_changed);
      checked++;
   endtask
endclass

module testbench;
   import ddsf_pkg::*;

   // addresses past the last register, writes there must be dropped
   localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [2:0] REG_SPARE_HIGH = 3'd7;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 58;
   localparam int CALM_PHASE      = 6;
   localparam int IDLE_PCT        = 12;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic signed [15:0] req_joystick_x;
   logic signed [15:0] req_joystick_y;
   logic signed [15:0] req_throttle;
   logic        [15:0] req_elapsed_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [7:0]  rsp_left_speed;
   logic signed [7:0]  rsp_right_speed;
   logic               rsp_left_dir_a;
   logic               rsp_left_dir_b;
   logic        [7:0]  rsp_left_pwm;
   logic               rsp_right_dir_a;
   logic               rsp_right_dir_b;
   logic        [7:0]  rsp_right_pwm;
   logic               rsp_failsafe_active;
   logic               rsp_outputs_changed;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic        [4:0]  csr_paddr;
   logic        [31:0] csr_pwdata;
   logic        [31:0] csr_prdata;
   logic               csr_pready;

   logic                   calm;
   motor_status_scoreboard status_sb;

   diff_drive_slew_failsafe dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      motor_status_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.left_speed      = rsp_left_speed;
         got.right_speed     = rsp_right_speed;
         got.left_dir_a      = rsp_left_dir_a;
         got.left_dir_b      = rsp_left_dir_b;
         got.left_pwm        = rsp_left_pwm;
         got.right_dir_a     = rsp_right_dir_a;
         got.right_dir_b     = rsp_right_dir_b;
         got.right_pwm       = rsp_right_pwm;
         got.failsafe_active = rsp_failsafe_active;
         got.outputs_changed = rsp_outputs_changed;
         status_sb.check_status(got);
      end
   end

   task automatic send_item(logic op, logic signed [15:0] jx, logic signed [15:0] jy,
                            logic signed [15:0] thr, logic [15:0] elapsed);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_joystick_x <= jx;
      req_joystick_y <= jy;
      req_throttle   <= thr;
      req_elapsed_ms <= elapsed;
      do @(posedge clock); while (!req_ready);
      status_sb.note_item(op, jx, jy, thr, elapsed);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (status_sb.expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write, then read back known registers
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      status_sb.set_register(idx, value);
      if (idx <= REG_MIN_PWM) begin
         @(posedge clock);
         csr_psel   <= 1'b1;
         csr_pwrite <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         if (csr_prdata !== status_sb.register_value(idx)) begin
            status_sb.report_mismatch("register read", int'(csr_prdata),
                                      int'(status_sb.register_value(idx)));
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_step();
      return ($urandom_range(3) == 0) ? 8'($urandom_range(200)) : 8'($urandom_range(1, 20));
   endfunction

   task automatic configure_phase(int ph);
      logic [6:0]  db;
      logic [7:0]  st;
      logic [7:0]  sts;
      logic [15:0] to;
      logic [7:0]  mp;
      logic [31:0] junk;
      case (ph)
         1: begin
            db = 7'd0;   st = 8'd200; sts = 8'd200; to = 16'd0;     mp = 8'd0;   junk = '0;
         end
         2: begin
            db = 7'd100; st = 8'd0;   sts = 8'd0;   to = 16'hFFFF;  mp = 8'd255; junk = '0;
         end
         3: begin
            db = 7'd10;  st = 8'd1;   sts = 8'd3;   to = 16'd1;     mp = 8'd255;
            junk = 32'hFFFF_0000;
         end
         default: begin
            db   = 7'($urandom_range(100));
            st   = pick_step();
            sts  = pick_step();
            to   = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(20, 600));
            mp   = 8'($urandom_range(255));
            junk = ($urandom_range(1) == 1) ? ($urandom & 32'hFFFF_0000) : '0;
         end
      endcase
      csr_write(REG_DEADBAND, junk | 32'(db));
      csr_write(REG_SLEW_STEP, junk | 32'(st));
      csr_write(REG_SLEW_STEP_STOP, junk | 32'(sts));
      csr_write(REG_FAILSAFE_TIMEOUT, junk | 32'(to));
      csr_write(REG_MIN_PWM, junk | 32'(mp));
      if (ph == 3) begin
         csr_write(REG_SPARE_LOW, $urandom);
         csr_write(REG_SPARE_HIGH, $urandom);
      end
   endtask

   function automatic logic signed [15:0] pick_axis();
      int v;
      if ($urandom_range(99) < 85) begin
         v = int'($urandom_range(240)) - 120;
         return 16'(v);
      end
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] pick_throttle();
      int v;
      if ($urandom_range(99) < 80) begin
         v = int'($urandom_range(120)) - 10;
         return 16'(v);
      end
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int r;
      r = $urandom_range(99);
      if (r < 85) begin
         return 16'($urandom_range(60));
      end else if (r < 95) begin
         return 16'($urandom_range(1000));
      end
      return 16'($urandom);
   endfunction

   task automatic random_item();
      if ($urandom_range(99) < 30) begin
         send_item(OP_DRIVE, pick_axis(), pick_axis(), pick_throttle(), 16'($urandom));
      end else begin
         send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), pick_elapsed());
      end
   endtask

   initial begin
      status_sb      = new();
      calm           = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_DRIVE;
      req_joystick_x = '0;
      req_joystick_y = '0;
      req_throttle   = '0;
      req_elapsed_ms = '0;
      rsp_ready      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // register defaults: field extremes, truncation, timer saturation
      send_item(OP_TICK, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0);
      send_item(OP_DRIVE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
      repeat (3) send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_item(OP_DRIVE, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_item(OP_DRIVE, 16'd0, 16'd33, 16'd50, 16'd0);
      send_item(OP_DRIVE, 16'd0, 16'hFFDF, 16'd50, 16'd0);
      send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd1);
      send_item(OP_DRIVE, 16'd100, 16'd100, 16'd100, 16'd0);
      repeat (4) send_item(OP_TICK, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1);
      send_item(OP_DRIVE, 16'hFF9C, 16'hFF9C, 16'd100, 16'd0);
      repeat (2) send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      drain();

      for (int ph = 1; ph < PHASES; ph++) begin
         configure_phase(ph);
         calm <= (ph == CALM_PHASE);
         if (ph == 2) begin
            // largest timeout crossed before the timer saturates, then the timer saturates
            send_item(OP_DRIVE, 16'd50, 16'd50, 16'd100, 16'd0);
            repeat (2) send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd40000);
            send_item(OP_TICK, 16'd0, 16'd0, 16'd0, 16'hFFFF);
            send_item(OP_DRIVE, 16'd0, 16'h8000, 16'd100, 16'd0);
         end
         repeat (ITEMS_PER_PHASE) random_item();
         drain();
      end

      if (status_sb.mismatches == 0 && status_sb.expected_status_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/ddsf_pkg.sv
rtl/core/diff_drive_slew_failsafe.sv
rtl/core/ddsf_checker.sv
dv/testbench.sv
